// ----- rtl/phh_pkg.sv -----
`timescale 1ns / 1ps
// Package for the pulse height histogram: shared constants, register
// indexes and the item record passed from the front end to the back end.
// No dependencies.
package phh_pkg;

  // Default sizes for the top-level parameters.
  localparam int unsigned HIST_BINS_DEF  = 128;
  localparam int unsigned COUNT_BITS_DEF = 32;

  // Sample and field widths.
  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned READ_BIN_W = 7;
  localparam int unsigned BIN_W      = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 12;

  // Register reset values.
  localparam logic [SAMPLE_W-1:0] THRESHOLD_RST = 12'd200;
  localparam logic [6:0]          LOW_RST       = 7'd4;
  localparam logic [7:0]          HIGH_RST      = 8'd126;

  // Bin arithmetic: bin = (peak >> BIN_SHIFT) - BIN_OFFSET.
  localparam int unsigned         BIN_SHIFT  = 4;
  localparam logic [BIN_W-1:0]    BIN_OFFSET = 8'h80;

  // Decoupling queue between front and back; a power of two so the
  // pointers wrap on their own.
  localparam int unsigned Q_DEPTH = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_LOW_LIMIT = 2'd1,
    CFG_HIGH_LIMIT = 2'd2
  } cfg_reg_e;

  // What the back end must do with an item.
  typedef enum logic [1:0] {
    OP_NONE,
    OP_READ,
    OP_COUNT
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic [BIN_W-1:0]    addr;
    logic                indicator;
    logic                done;
    logic [SAMPLE_W-1:0] peak;
    logic [BIN_W-1:0]    bin;
  } item_t;

endpackage

// ----- rtl/phh_intf.sv -----
`timescale 1ns / 1ps
// Channel interfaces of the pulse height histogram: sample/read input,
// result output and configuration write. Depends on phh_pkg.
interface phh_in_if ();
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic [phh_pkg::SAMPLE_W-1:0]        reference_sample;
  logic [phh_pkg::SAMPLE_W-1:0]        signal_sample;
  logic [phh_pkg::READ_BIN_W-1:0]      read_bin;

  modport source (output valid, kind, reference_sample, signal_sample, read_bin,
                  input ready);
  modport sink (input valid, kind, reference_sample, signal_sample, read_bin,
                output ready);
endinterface

interface phh_out_if #(
  parameter int unsigned COUNT_BITS = phh_pkg::COUNT_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic                          pulse_indicator;
  logic                          pulse_done;
  logic [phh_pkg::SAMPLE_W-1:0]  peak_value;
  logic signed [phh_pkg::BIN_W-1:0] bin_index;
  logic                          counted;
  logic [COUNT_BITS-1:0]         bin_count;
  logic [COUNT_BITS-1:0]         total_count;

  modport source (output valid, pulse_indicator, pulse_done, peak_value, bin_index,
                  counted, bin_count, total_count, input ready);
  modport sink (input valid, pulse_indicator, pulse_done, peak_value, bin_index,
                counted, bin_count, total_count, output ready);
endinterface

interface phh_cfg_if ();
  logic                               valid;
  logic                               ready;
  logic [phh_pkg::CFG_IDX_W-1:0]      index;
  logic [phh_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/phh_front.sv -----
`timescale 1ns / 1ps
// Front end: configuration registers, pulse detector and classification of
// each input beat into a back-end operation. Depends on phh_pkg, phh_intf.
module phh_front #(
  parameter int unsigned HIST_BINS = phh_pkg::HIST_BINS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  phh_cfg_if.sink         cfg_i,
  phh_in_if.sink          in_i,
  output logic            push_valid_o,
  input  logic            push_ready_i,
  output phh_pkg::item_t  push_item_o
);

  localparam int unsigned SW = phh_pkg::SAMPLE_W;

  logic [SW-1:0] thr_q, thr_d;
  logic [6:0]    low_q, low_d;
  logic [7:0]    high_q, high_d;

  logic [SW-1:0] peak_q, peak_d;
  logic          disarmed_q, disarmed_d;
  logic          ind_q, ind_d;

  logic                          accept;
  logic                          above;
  logic [phh_pkg::BIN_W-1:0]     bin8;
  logic signed [9:0]             bin_w;
  logic                          in_limits;
  phh_pkg::item_t                item;

  assign cfg_i.ready  = 1'b1;
  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid;
  assign push_item_o  = item;
  assign accept       = in_i.valid && push_ready_i;

  always_comb begin
    thr_d  = thr_q;
    low_d  = low_q;
    high_d = high_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        phh_pkg::CFG_THRESHOLD:  thr_d  = cfg_i.data;
        phh_pkg::CFG_LOW_LIMIT:  low_d  = cfg_i.data[6:0];
        phh_pkg::CFG_HIGH_LIMIT: high_d = cfg_i.data[7:0];
        default: ;
      endcase
    end
  end

  // Bin of the held peak, sign-extended so that the limit compares are signed.
  assign bin8      = peak_q[SW-1:phh_pkg::BIN_SHIFT] - phh_pkg::BIN_OFFSET;
  assign bin_w     = $signed({{2{bin8[7]}}, bin8});
  assign in_limits = (bin_w > $signed({3'b000, low_q}))
                  && (bin_w < $signed({2'b00, high_q}))
                  && (bin_w < $signed(10'(HIST_BINS)));

  assign above = {1'b0, in_i.signal_sample} > ({1'b0, in_i.reference_sample} + {1'b0, thr_q});

  always_comb begin
    peak_d         = peak_q;
    disarmed_d     = disarmed_q;
    ind_d          = ind_q;
    item           = '0;
    item.op        = phh_pkg::OP_NONE;
    if (in_i.kind) begin
      if ({2'b00, in_i.read_bin} < 9'(HIST_BINS)) begin
        item.op = phh_pkg::OP_READ;
      end
      item.addr = {1'b0, in_i.read_bin};
    end else if (above) begin
      if (!disarmed_q) begin
        if (in_i.signal_sample >= peak_q) begin
          peak_d = in_i.signal_sample;
        end else begin
          item.done  = 1'b1;
          item.peak  = peak_q;
          item.bin   = bin8;
          item.addr  = bin8;
          if (in_limits) begin
            item.op = phh_pkg::OP_COUNT;
          end
          peak_d     = '0;
          disarmed_d = 1'b1;
        end
        ind_d = 1'b1;
      end
    end else begin
      disarmed_d = 1'b0;
      ind_d      = 1'b0;
    end
    item.indicator = ind_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q      <= phh_pkg::THRESHOLD_RST;
      low_q      <= phh_pkg::LOW_RST;
      high_q     <= phh_pkg::HIGH_RST;
      peak_q     <= '0;
      disarmed_q <= 1'b0;
      ind_q      <= 1'b0;
    end else begin
      thr_q  <= thr_d;
      low_q  <= low_d;
      high_q <= high_d;
      if (accept) begin
        peak_q     <= peak_d;
        disarmed_q <= disarmed_d;
        ind_q      <= ind_d;
      end
    end
  end

endmodule

// ----- rtl/phh_queue.sv -----
`timescale 1ns / 1ps
// Short FIFO of item records between the front and back ends.
// Depends on phh_pkg.
module phh_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  phh_pkg::item_t  push_item_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output phh_pkg::item_t  pop_item_o
);

  localparam int unsigned PTR_W = $clog2(phh_pkg::Q_DEPTH);
  localparam int unsigned CNT_W = $clog2(phh_pkg::Q_DEPTH + 1);

  phh_pkg::item_t   slots_q [phh_pkg::Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             push, pop;

  assign push_ready_o = cnt_q != CNT_W'(phh_pkg::Q_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_item_o   = slots_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - CNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ----- rtl/phh_back.sv -----
`timescale 1ns / 1ps
// Back end: histogram memory read-modify-write with forwarding, total
// counter and output register. Depends on phh_pkg, phh_intf.
module phh_back #(
  parameter int unsigned HIST_BINS  = phh_pkg::HIST_BINS_DEF,
  parameter int unsigned COUNT_BITS = phh_pkg::COUNT_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            head_valid_i,
  output logic            head_ready_o,
  input  phh_pkg::item_t  head_item_i,
  phh_out_if.source       out_o
);

  localparam int unsigned IDX_W = $clog2(HIST_BINS);

  logic [COUNT_BITS-1:0] hist_mem [HIST_BINS];
  logic [HIST_BINS-1:0]  bin_vld_q;

  phh_pkg::item_t        s2_q;
  logic                  s2_valid_q;
  logic [COUNT_BITS-1:0] rd_data_q;
  logic                  rd_vld_q;
  logic                  fwd_q, fwd_d;
  logic [COUNT_BITS-1:0] fwd_data_q;
  logic [COUNT_BITS-1:0] total_q;

  phh_pkg::item_t        res_q;
  logic [COUNT_BITS-1:0] res_count_q, res_total_q;
  logic                  out_valid_q;

  logic                  s2_move, pop, wr_en;
  logic [IDX_W-1:0]      s2_idx, head_idx;
  logic [COUNT_BITS-1:0] base, new_count, count_d, total_d;

  assign s2_idx   = s2_q.addr[IDX_W-1:0];
  assign head_idx = head_item_i.addr[IDX_W-1:0];

  assign s2_move      = s2_valid_q && (!out_valid_q || out_o.ready);
  assign head_ready_o = !s2_valid_q || s2_move;
  assign pop          = head_valid_i && head_ready_o;
  assign wr_en        = s2_move && (s2_q.op == phh_pkg::OP_COUNT);

  // A bin written by the item just ahead is taken from the forward path,
  // since the memory read for this item happened before that write landed.
  assign base      = fwd_q ? fwd_data_q : (rd_vld_q ? rd_data_q : '0);
  assign new_count = base + COUNT_BITS'(1);
  assign total_d   = (s2_q.op == phh_pkg::OP_COUNT) ? total_q + COUNT_BITS'(1) : total_q;

  always_comb begin
    case (s2_q.op)
      phh_pkg::OP_COUNT: count_d = new_count;
      phh_pkg::OP_READ:  count_d = base;
      default:           count_d = '0;
    endcase
  end

  always_comb begin
    fwd_d = fwd_q;
    if (pop) begin
      fwd_d = wr_en && (s2_idx == head_idx);
    end else if (s2_move) begin
      fwd_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      hist_mem[s2_idx] <= new_count;
    end
    if (pop) begin
      rd_data_q  <= hist_mem[head_idx];
      fwd_data_q <= new_count;
      s2_q       <= head_item_i;
    end
    if (s2_move) begin
      res_q       <= s2_q;
      res_count_q <= count_d;
      res_total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_vld_q   <= '0;
      rd_vld_q    <= 1'b0;
      fwd_q       <= 1'b0;
      s2_valid_q  <= 1'b0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fwd_q <= fwd_d;
      if (wr_en) begin
        bin_vld_q[s2_idx] <= 1'b1;
      end
      if (pop) begin
        rd_vld_q <= bin_vld_q[head_idx];
      end
      if (pop) begin
        s2_valid_q <= 1'b1;
      end else if (s2_move) begin
        s2_valid_q <= 1'b0;
      end
      if (s2_move) begin
        total_q <= total_d;
      end
      if (s2_move) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.pulse_indicator = res_q.indicator;
  assign out_o.pulse_done      = res_q.done;
  assign out_o.peak_value      = res_q.peak;
  assign out_o.bin_index       = $signed(res_q.bin);
  assign out_o.counted         = res_q.op == phh_pkg::OP_COUNT;
  assign out_o.bin_count       = res_count_q;
  assign out_o.total_count     = res_total_q;

`ifndef SYNTHESIS
  // The forward flag only ever refers to an item sitting in the second stage.
  a_fwd_needs_s2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> s2_valid_q) else $error("forward flag set without an item in stage 2");

  // A counted pulse bumps the total by exactly one.
  a_total_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> total_q == $past(total_q) + COUNT_BITS'(1))
    else $error("total did not advance on a counted pulse");

  // Without a counted pulse the total holds.
  a_total_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !wr_en |=> $stable(total_q)) else $error("total changed without a counted pulse");

  // An item leaving stage 2 always lands in the output register.
  a_move_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_move |=> out_valid_q) else $error("result lost between stage 2 and output");
`endif

endmodule

// ----- rtl/pulse_height_histogram.sv -----
`timescale 1ns / 1ps
// Top level of the pulse height histogram: front end, queue and back end.
// Depends on phh_pkg, phh_intf, phh_front, phh_queue and phh_back.
//
// Usage. Input beats arrive on in_i: a sample pair (kind 0) or a request to
// read one histogram bin (kind 1). Every accepted beat produces exactly one
// result beat on out_o, in order. The front end tracks the pulse peak and
// decides, in the cycle of acceptance, whether the beat ends a pulse and
// whether that pulse is counted. The back end performs the histogram
// read-modify-write in a two-stage path with forwarding, so successive hits
// on the same bin are counted correctly.
// Throughput is one beat per cycle while out_o does not stall; the histogram
// memory has one read and one write port, and back-to-back updates of one
// bin are served from the forward register. A beat reaches out_o through the
// queue, stage 2 and the output register. Configuration is written on cfg_i
// (index 0 threshold, 1 lower bin limit, 2 upper bin limit) while the block
// is idle. Reset restores the register defaults and clears the histogram at
// once through per-bin valid bits, so no clearing pass is needed. When the
// receiver stalls, the output register, stage 2 and a four-entry queue fill
// up before in_i.ready drops; nothing is lost or repeated.
module pulse_height_histogram #(
  parameter int unsigned HIST_BINS  = phh_pkg::HIST_BINS_DEF,
  parameter int unsigned COUNT_BITS = phh_pkg::COUNT_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  phh_cfg_if.sink    cfg_i,
  phh_in_if.sink     in_i,
  phh_out_if.source  out_o
);

  // Front end to queue.
  logic           push_valid, push_ready;
  phh_pkg::item_t push_item;

  // Queue to back end.
  logic           head_valid, head_ready;
  phh_pkg::item_t head_item;

  phh_front #(
    .HIST_BINS (HIST_BINS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_i),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  phh_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (head_valid),
    .pop_ready_i  (head_ready),
    .pop_item_o   (head_item)
  );

  phh_back #(
    .HIST_BINS  (HIST_BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_ready_o (head_ready),
    .head_item_i  (head_item),
    .out_o        (out_o)
  );

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for pulse_height_histogram: sends sample and read beats,
// predicts each result beat and checks it field by field as it leaves.
// Depends on phh_pkg, the channel interfaces in phh_intf and the block RTL.
module testbench;

  // Sizes of the instance under test, left at the package defaults.
  localparam int HIST_SIZE = phh_pkg::HIST_BINS_DEF;
  localparam int COUNT_W   = phh_pkg::COUNT_BITS_DEF;

  // Meaning of the kind field of an input beat.
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  // The one index on the configuration channel that selects no register.
  localparam logic [phh_pkg::CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

  // Cycles allowed after the last expected result before the block counts as
  // idle.
  localparam int SETTLE_CYCLES = 8;
  // Length of the long receiver hold-off in the back-pressure test.
  localparam int HOLD_CYCLES   = 80;
  // Random beats per configuration phase.
  localparam int PHASE_BEATS   = 250;
  // Mismatch lines printed before the rest are only counted.
  localparam int MAX_REPORTS   = 40;

  typedef struct packed {
    logic                           kind;
    logic [phh_pkg::SAMPLE_W-1:0]   base_level;
    logic [phh_pkg::SAMPLE_W-1:0]   sig_level;
    logic [phh_pkg::READ_BIN_W-1:0] rbin;
  } beat_t;

  typedef struct packed {
    logic                             indicator;
    logic                             done;
    logic [phh_pkg::SAMPLE_W-1:0]     peak;
    logic signed [phh_pkg::BIN_W-1:0] bin_idx;
    logic                             counted;
    logic [COUNT_W-1:0]               bin_count;
    logic [COUNT_W-1:0]               total;
  } result_t;

  logic clk_i;
  logic rst_ni;

  phh_in_if                        in_if ();
  phh_out_if #(.COUNT_BITS(COUNT_W)) out_if ();
  phh_cfg_if                       cfg_if ();

  pulse_height_histogram #(
    .HIST_BINS (HIST_SIZE),
    .COUNT_BITS(COUNT_W)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // 100 MHz clock.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor state: a private copy of the registers and of everything the
  // block remembers between beats.
  // ---------------------------------------------------------------------
  logic [phh_pkg::SAMPLE_W-1:0] threshold;
  logic [6:0]                   low_limit;
  logic [7:0]                   high_limit;
  logic [phh_pkg::SAMPLE_W-1:0] peak_held;
  logic                         disarmed;
  logic                         indicator;
  logic [COUNT_W-1:0]           hist_counts [HIST_SIZE];
  logic [COUNT_W-1:0]           total_pulses;

  // Results that have been predicted but not yet seen on the output.
  result_t pending_results [$];

  int unsigned beats_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches   = 0;

  // Stimulus controls. When tx_burst or rx_burst is set that side never idles;
  // hold_off forces the receiver to stall for the back-pressure test.
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;
  bit hold_off = 1'b0;
  int stall_left = 0;

  // Most recently finished pulse bin, so that reads often hit a live bin.
  logic [phh_pkg::READ_BIN_W-1:0] last_bin = '0;

  task automatic clear_predictor();
    threshold    = phh_pkg::THRESHOLD_RST;
    low_limit    = phh_pkg::LOW_RST;
    high_limit   = phh_pkg::HIGH_RST;
    peak_held    = '0;
    disarmed     = 1'b0;
    indicator    = 1'b0;
    total_pulses = '0;
    foreach (hist_counts[i]) hist_counts[i] = '0;
  endtask

  // Works out the result beat that one input beat causes and moves the
  // predictor state on. A sample above the threshold either raises the held
  // peak or, once it falls below it, ends the pulse and maybe counts it.
  function automatic result_t predict_pulse_result(input beat_t b);
    result_t r;
    int      bin;
    r = '0;
    if (b.kind == KIND_READ) begin
      r.bin_count = hist_counts[b.rbin];
    end else if (int'(b.sig_level) > int'(b.base_level) + int'(threshold)) begin
      // Above threshold while disarmed leaves everything, indicator included.
      if (!disarmed) begin
        if (b.sig_level >= peak_held) begin
          peak_held = b.sig_level;
        end else begin
          bin       = int'(peak_held >> phh_pkg::BIN_SHIFT) - int'(phh_pkg::BIN_OFFSET);
          r.done    = 1'b1;
          r.peak    = peak_held;
          r.bin_idx = bin[phh_pkg::BIN_W-1:0];
          // Both limits are strict; a negative bin never passes the lower one.
          if (bin > int'(low_limit) && bin < int'(high_limit) && bin < HIST_SIZE) begin
            hist_counts[bin] = hist_counts[bin] + 1'b1;
            total_pulses     = total_pulses + 1'b1;
            r.counted        = 1'b1;
            r.bin_count      = hist_counts[bin];
          end
          peak_held = '0;
          disarmed  = 1'b1;
        end
        indicator = 1'b1;
      end
    end else begin
      // Dropping below the threshold re-arms but keeps the held peak.
      disarmed  = 1'b0;
      indicator = 1'b0;
    end
    r.indicator = indicator;
    r.total     = total_pulses;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Checking.
  // ---------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_REPORTS) $display("[%0t] MISMATCH %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [COUNT_W-1:0] got,
                             input logic [COUNT_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
                                results_seen, name, got, want));
  endtask

  // Every result beat is taken at the rising edge and matched against the
  // oldest prediction. The bin index is compared as its eight raw bits.
  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no beat outstanding",
                                  results_seen));
      end else begin
        want = pending_results.pop_front();
        check_field("pulse_indicator", out_if.pulse_indicator, want.indicator);
        check_field("pulse_done", out_if.pulse_done, want.done);
        check_field("peak_value", out_if.peak_value, want.peak);
        check_field("bin_index", out_if.bin_index[phh_pkg::BIN_W-1:0],
                    want.bin_idx[phh_pkg::BIN_W-1:0]);
        check_field("counted", out_if.counted, want.counted);
        check_field("bin_count", out_if.bin_count, want.bin_count);
        check_field("total_count", out_if.total_count, want.total);
      end
      results_seen++;
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: ready changes at the falling edge. Mostly ready, with short
  // stalls and the odd long one, unless a burst or a hold-off is in force.
  // ---------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_off) begin
      out_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left--;
    end else if (rx_burst || $urandom_range(0, 99) < 70) begin
      out_if.ready <= 1'b1;
    end else begin
      out_if.ready <= 1'b0;
      stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                : $urandom_range(9, 29);
    end
  end

  // ---------------------------------------------------------------------
  // Sender side.
  // ---------------------------------------------------------------------
  function automatic int pick_gap();
    int unsigned roll;
    if (tx_burst) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // The unused fields of a beat carry random bits, so every input bit toggles.
  function automatic beat_t sample_beat(input int base_lvl, input int sig_lvl);
    beat_t b;
    b.kind       = KIND_SAMPLE;
    b.base_level = base_lvl[phh_pkg::SAMPLE_W-1:0];
    b.sig_level  = sig_lvl[phh_pkg::SAMPLE_W-1:0];
    b.rbin       = $urandom_range(0, HIST_SIZE - 1);
    return b;
  endfunction

  function automatic beat_t read_beat(input int bin);
    beat_t b;
    b.kind       = KIND_READ;
    b.base_level = $urandom_range(0, 4095);
    b.sig_level  = $urandom_range(0, 4095);
    b.rbin       = bin[phh_pkg::READ_BIN_W-1:0];
    return b;
  endfunction

  // Offers one beat from the falling edge, waits for it to be taken, records
  // the prediction and then idles for a random gap. With no gap, valid stays
  // high and the next call simply changes the payload.
  task automatic send_beat(input beat_t b);
    result_t r;
    int      gap;
    @(negedge clk_i);
    in_if.valid            <= 1'b1;
    in_if.kind             <= b.kind;
    in_if.reference_sample <= b.base_level;
    in_if.signal_sample    <= b.sig_level;
    in_if.read_bin         <= b.rbin;
    forever begin
      @(posedge clk_i);
      if (in_if.ready === 1'b1) break;
    end
    r = predict_pulse_result(b);
    if (r.done) last_bin = r.bin_idx[phh_pkg::READ_BIN_W-1:0];
    pending_results.push_back(r);
    beats_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // Stops offering beats and waits until every result has come back.
  task automatic drain_results();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Registers are only written once the block has gone quiet.
  task automatic write_reg(input logic [phh_pkg::CFG_IDX_W-1:0] index,
                           input logic [phh_pkg::CFG_DATA_W-1:0] data);
    drain_results();
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= index;
    cfg_if.data  <= data;
    forever begin
      @(posedge clk_i);
      if (cfg_if.ready === 1'b1) break;
    end
    // Each register keeps only its own width; other indexes are ignored.
    case (index)
      phh_pkg::CFG_THRESHOLD:  threshold  = data;
      phh_pkg::CFG_LOW_LIMIT:  low_limit  = data[6:0];
      phh_pkg::CFG_HIGH_LIMIT: high_limit = data[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // One well-formed pulse with random content: a rise to the peak, perhaps a
  // flat top, the falling sample that ends it, some ignored samples while
  // disarmed, and a return below threshold. One pulse in ten leaves out the
  // return, so the next one starts disarmed.
  task automatic send_pulse(input int lo_peak, input int hi_peak);
    int peak;
    int top;
    int floor_lvl;
    int base;
    int lvl;
    peak = $urandom_range(lo_peak, hi_peak);
    top  = peak - int'(threshold) - 1;
    if (top < 0) begin
      // The threshold is too high for this peak; a plain sample stands in.
      send_beat(sample_beat($urandom_range(0, 4095), peak));
      return;
    end
    if (top > 64 && $urandom_range(0, 1) == 1) top = 64;
    floor_lvl = $urandom_range(0, top);
    base      = floor_lvl + int'(threshold) + 1;
    lvl       = base;
    repeat ($urandom_range(0, 3)) begin
      lvl = $urandom_range(lvl, peak);
      send_beat(sample_beat(floor_lvl, lvl));
    end
    send_beat(sample_beat(floor_lvl, peak));
    if ($urandom_range(0, 4) == 0) send_beat(sample_beat(floor_lvl, peak));
    if (peak > base) send_beat(sample_beat(floor_lvl, $urandom_range(base, peak - 1)));
    repeat ($urandom_range(0, 2)) send_beat(sample_beat(floor_lvl, $urandom_range(base, 4095)));
    if ($urandom_range(0, 9) != 0)
      repeat ($urandom_range(1, 2)) send_beat(sample_beat(floor_lvl, $urandom_range(0, base - 1)));
  endtask

  // ---------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------

  // A cleared histogram reads zero at both ends, and a quiet sample keeps
  // the indicator low.
  task automatic test_reset_state();
    send_beat(read_beat(0));
    send_beat(read_beat(HIST_SIZE - 1));
    send_beat(sample_beat(0, 0));
  endtask

  // Hand-built pulses under the reset limits (threshold 200, bins 5 to 125).
  task automatic test_pulse_cases();
    // Full-scale peak, held through an equal sample; its bin is 127, above
    // the upper limit, so it finishes uncounted.
    send_beat(sample_beat(0, 4095));
    send_beat(sample_beat(0, 4095));
    send_beat(sample_beat(0, 4000));
    // Still above threshold but disarmed: nothing moves, indicator stays high.
    send_beat(sample_beat(0, 4095));
    // Both channels at full scale is not a pulse, so this re-arms.
    send_beat(sample_beat(4095, 4095));
    // Two pulses into bin 9, the read after each showing the running count.
    send_beat(sample_beat(100, 2200));
    send_beat(sample_beat(100, 2100));
    send_beat(read_beat(9));
    send_beat(sample_beat(0, 0));
    send_beat(sample_beat(0, 2207));
    send_beat(sample_beat(0, 2150));
    send_beat(read_beat(9));
    send_beat(sample_beat(0, 0));
    // A small pulse gives a negative bin, which is never counted.
    send_beat(sample_beat(0, 300));
    send_beat(sample_beat(0, 250));
    // Signal exactly at reference plus threshold is not above it: re-arm.
    send_beat(sample_beat(100, 300));
    // Re-arming keeps the held peak, so the next armed sample below it ends
    // the pulse at once with the old peak (bin 59, counted).
    send_beat(sample_beat(0, 3000));
    send_beat(sample_beat(0, 150));
    send_beat(sample_beat(0, 2800));
    send_beat(sample_beat(0, 0));
    // A bin equal to the lower limit fails the strict comparison.
    send_beat(sample_beat(0, 2112));
    send_beat(sample_beat(0, 2100));
    send_beat(sample_beat(0, 0));
  endtask

  // Every register written, upper data bits masked off, the unused index
  // ignored, then a short check of the new limits.
  task automatic test_register_writes();
    write_reg(CFG_NO_REG, 12'hFFF);
    write_reg(phh_pkg::CFG_THRESHOLD, 12'd0);
    write_reg(phh_pkg::CFG_LOW_LIMIT, 12'hF80);
    write_reg(phh_pkg::CFG_HIGH_LIMIT, 12'hF80);
    // Bin 0 fails a lower limit of 0; bin 1 passes with the upper limit at 128.
    send_beat(sample_beat(0, 2048));
    send_beat(sample_beat(0, 2047));
    send_beat(sample_beat(0, 0));
    send_beat(sample_beat(0, 2064));
    send_beat(sample_beat(0, 2050));
    send_beat(read_beat(1));
    send_beat(sample_beat(0, 0));
  endtask

  // The receiver holds off for a long stretch while beats keep coming, so
  // the output stage and the internal queue fill and the input stalls.
  task automatic test_backpressure();
    drain_results();
    tx_burst = 1'b1;
    fork
      begin
        @(posedge clk_i);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off = 1'b0;
      end
    join_none
    repeat (6) send_pulse(2048, 4095);
    tx_burst = 1'b0;
    drain_results();
  endtask

  // One configuration phase of random traffic: mostly pulses, some reads,
  // some unshaped samples. A narrow phase keeps peaks to a few bins so the
  // same counters are hit again and again.
  task automatic run_random_phase(input logic [phh_pkg::CFG_DATA_W-1:0] thr_data,
                                  input logic [phh_pkg::CFG_DATA_W-1:0] low_data,
                                  input logic [phh_pkg::CFG_DATA_W-1:0] high_data,
                                  input bit narrow, input int beats);
    int unsigned first;
    int unsigned roll;
    write_reg(phh_pkg::CFG_THRESHOLD, thr_data);
    write_reg(phh_pkg::CFG_LOW_LIMIT, low_data);
    write_reg(phh_pkg::CFG_HIGH_LIMIT, high_data);
    first = beats_sent;
    while (beats_sent - first < beats) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        if (narrow) send_pulse(2048 + 16 * 5, 2048 + 16 * 8 - 1);
        else if ($urandom_range(0, 3) != 0) send_pulse(2048, 4095);
        else send_pulse(0, 4095);
      end else if (roll < 82) begin
        if ($urandom_range(0, 1) == 1) send_beat(read_beat(int'(last_bin)));
        else send_beat(read_beat($urandom_range(0, HIST_SIZE - 1)));
      end else begin
        send_beat(sample_beat($urandom_range(0, 4095), $urandom_range(0, 4095)));
      end
    end
  endtask

  task automatic test_random_phases();
    run_random_phase(phh_pkg::THRESHOLD_RST, phh_pkg::LOW_RST, phh_pkg::HIGH_RST, 1'b0,
                     PHASE_BEATS);
    tx_burst = 1'b1;
    run_random_phase(12'd0, 12'd0, 12'd128, 1'b0, PHASE_BEATS);
    tx_burst = 1'b0;
    // Nothing can rise above the largest threshold, and the limits shut out
    // every bin.
    run_random_phase(12'd4095, 12'd127, 12'd0, 1'b0, PHASE_BEATS / 2);
    rx_burst = 1'b1;
    run_random_phase($urandom_range(0, 4095), $urandom_range(0, 4095),
                     $urandom_range(0, 4095), 1'b0, PHASE_BEATS);
    rx_burst = 1'b0;
    run_random_phase(12'd10, 12'd0, 12'hFFF, 1'b0, PHASE_BEATS);
    run_random_phase(12'd100, 12'd127, 12'd128, 1'b0, PHASE_BEATS / 2);
    tx_burst = 1'b1;
    rx_burst = 1'b1;
    run_random_phase(12'd50, 12'd4, 12'd8, 1'b1, PHASE_BEATS);
    tx_burst = 1'b0;
    rx_burst = 1'b0;
    run_random_phase($urandom_range(0, 600), $urandom_range(0, 20),
                     $urandom_range(100, 255), 1'b1, PHASE_BEATS);
    run_random_phase($urandom_range(0, 4095), $urandom_range(0, 127),
                     $urandom_range(0, 128), 1'b0, PHASE_BEATS);
  endtask

  // ---------------------------------------------------------------------
  // Sequence: reset once, run the tests in turn, then give the verdict.
  // ---------------------------------------------------------------------
  initial begin
    rst_ni                 = 1'b0;
    in_if.valid            = 1'b0;
    in_if.kind             = KIND_SAMPLE;
    in_if.reference_sample = '0;
    in_if.signal_sample    = '0;
    in_if.read_bin         = '0;
    cfg_if.valid           = 1'b0;
    cfg_if.index           = phh_pkg::CFG_THRESHOLD;
    cfg_if.data            = '0;
    out_if.ready           = 1'b0;
    clear_predictor();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_state();
    test_pulse_cases();
    test_register_writes();
    test_backpressure();
    test_random_phases();

    drain_results();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: the whole run takes well under a tenth of this.
  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
